// File: hdl/assert_macros.svh
// Assertion macros shared by the fan tachometer monitor RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define FTM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define FTM_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);

`endif

// File: hdl/ftm_pkg.sv
// Package for the fan tachometer monitor: item types, codes and constants.
// Depends on nothing; used by every module of the block.
package ftm_pkg;

    // Event codes carried in the cmd field of an input item.
    localparam logic [1:0] CMD_EDGE = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_DUTY = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    // Fan status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_STALL = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PWM_TOP  = 2'd0;
    localparam logic [1:0] CFG_RPM_DUTY = 2'd1;
    localparam logic [1:0] CFG_TOL_PCT  = 2'd2;
    localparam logic [1:0] CFG_WINDOW   = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] RST_PWM_TOP  = 16'd639;
    localparam logic [9:0]  RST_RPM_DUTY = 10'd30;
    localparam logic [6:0]  RST_TOL_PCT  = 7'd80;
    localparam logic [15:0] RST_WINDOW   = 16'd1000;

    localparam logic [6:0]  DUTY_MAX   = 7'd100;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    // Division by 100 as a multiply by ceil(2^30 / 100) and a shift by 30.
    // Exact for dividends below 2^30 / 76, well above the largest product.
    localparam logic [23:0] RECIP_100   = 24'd10737419;
    localparam int          RECIP_SHIFT = 30;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] duty;
    } t_in_item;

    typedef struct packed {
        logic [15:0] rpm_out;
        logic [1:0]  fan_status;
        logic [15:0] compare_value;
        logic        window_done;
    } t_out_item;

    // Event state after the most recent item.
    typedef struct packed {
        logic [15:0] rpm;
        logic [6:0]  duty;
        logic        done;
    } t_evt_state;

    // Sequencer to top-level hand-off.
    typedef struct packed {
        logic        busy;
        logic        load;
        logic [15:0] compare_value;
        logic [1:0]  fan_status;
    } t_seq_out;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_MUL_TOP,
        SEQ_MUL_RECIP,
        SEQ_MUL_RPD,
        SEQ_MUL_TOL,
        SEQ_FINISH
    } t_seq_state;

endpackage

// File: hdl/ftm_state.sv
// Event state of the fan tachometer monitor: edge and tick counters, RPM latch, duty.
// Depends on ftm_pkg.
module ftm_state (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  ftm_pkg::t_in_item i_item,
    input  logic [15:0]       i_window_ms,
    output ftm_pkg::t_evt_state o_state
);

    localparam logic [15:0] COUNT_MAX_W = ftm_pkg::COUNT_MAX;

    logic [15:0] r_edge;
    logic [15:0] r_ms;
    logic [15:0] r_rpm;
    logic [6:0]  r_duty;
    logic        r_done;
    logic [15:0] n_edge;
    logic [15:0] n_ms;
    logic [15:0] n_rpm;
    logic [6:0]  n_duty;
    logic        n_done;

    logic [16:0] w_ms_next;
    logic        w_close;
    logic [14:0] w_half;
    logic [20:0] w_rpm_raw;
    logic [15:0] w_rpm_sat;

    // Window close test and the new speed: (edges / 2) * 60, saturated.
    assign w_ms_next = {1'b0, r_ms} + 17'd1;
    assign w_close   = (w_ms_next >= {1'b0, i_window_ms});
    assign w_half    = r_edge[15:1];
    assign w_rpm_raw = ({6'd0, w_half} << 6) - ({6'd0, w_half} << 2);
    assign w_rpm_sat = (w_rpm_raw > 21'(COUNT_MAX_W)) ? ftm_pkg::COUNT_MAX
                                                      : w_rpm_raw[15:0];

    // Next state for one accepted item.
    always_comb begin
        n_edge = r_edge;
        n_ms   = r_ms;
        n_rpm  = r_rpm;
        n_duty = r_duty;
        n_done = 1'b0;
        unique case (i_item.cmd)
            ftm_pkg::CMD_EDGE: begin
                if (r_edge != ftm_pkg::COUNT_MAX) begin
                    n_edge = r_edge + 16'd1;
                end
            end
            ftm_pkg::CMD_TICK: begin
                if (w_close) begin
                    n_rpm  = w_rpm_sat;
                    n_edge = '0;
                    n_ms   = '0;
                    n_done = 1'b1;
                end else begin
                    n_ms = w_ms_next[15:0];
                end
            end
            ftm_pkg::CMD_DUTY: begin
                n_duty = (i_item.duty > ftm_pkg::DUTY_MAX) ? ftm_pkg::DUTY_MAX
                                                           : i_item.duty;
            end
            ftm_pkg::CMD_NONE: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge <= '0;
            r_ms   <= '0;
            r_rpm  <= '0;
            r_duty <= '0;
            r_done <= 1'b0;
        end else if (i_accept) begin
            r_edge <= n_edge;
            r_ms   <= n_ms;
            r_rpm  <= n_rpm;
            r_duty <= n_duty;
            r_done <= n_done;
        end
    end

    assign o_state.rpm  = r_rpm;
    assign o_state.duty = r_duty;
    assign o_state.done = r_done;

endmodule

// File: hdl/ftm_seq.sv
// Sequencer and shared multiplier that form the PWM compare value and fan status.
// Depends on ftm_pkg.
module ftm_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_out_free,
    input  ftm_pkg::t_evt_state i_state,
    input  logic [15:0]         i_pwm_top,
    input  logic [9:0]          i_rpm_per_duty,
    input  logic [6:0]          i_tolerance_pct,
    output ftm_pkg::t_seq_out   o_seq
);

    ftm_pkg::t_seq_state r_state;
    ftm_pkg::t_seq_state n_state;

    logic [47:0] r_prod;
    logic [15:0] r_cmp;
    logic [23:0] w_op_a;
    logic [23:0] w_op_b;
    logic [16:0] w_rpm_inc;
    logic [23:0] w_rpm_ext;
    logic [23:0] w_thresh;
    logic [1:0]  w_status;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ftm_pkg::SEQ_IDLE:      if (i_start) n_state = ftm_pkg::SEQ_MUL_TOP;
            ftm_pkg::SEQ_MUL_TOP:   n_state = ftm_pkg::SEQ_MUL_RECIP;
            ftm_pkg::SEQ_MUL_RECIP: n_state = ftm_pkg::SEQ_MUL_RPD;
            ftm_pkg::SEQ_MUL_RPD:   n_state = ftm_pkg::SEQ_MUL_TOL;
            ftm_pkg::SEQ_MUL_TOL:   n_state = ftm_pkg::SEQ_FINISH;
            ftm_pkg::SEQ_FINISH:    if (i_out_free) n_state = ftm_pkg::SEQ_IDLE;
            default:                n_state = ftm_pkg::SEQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ftm_pkg::SEQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        unique case (r_state)
            ftm_pkg::SEQ_MUL_TOP: begin
                w_op_a = {8'd0, i_pwm_top};
                w_op_b = {17'd0, i_state.duty};
            end
            ftm_pkg::SEQ_MUL_RECIP: begin
                w_op_a = {1'b0, r_prod[22:0]};
                w_op_b = ftm_pkg::RECIP_100;
            end
            ftm_pkg::SEQ_MUL_RPD: begin
                w_op_a = {17'd0, i_state.duty};
                w_op_b = {14'd0, i_rpm_per_duty};
            end
            ftm_pkg::SEQ_MUL_TOL: begin
                w_op_a = {7'd0, r_prod[16:0]};
                w_op_b = {17'd0, i_tolerance_pct};
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    // Product register, held through the finish step so the status stays put while
    // the result waits; the compare value is taken once the reciprocal step is done.
    always_ff @(posedge i_clk) begin
        if (r_state != ftm_pkg::SEQ_FINISH) begin
            r_prod <= w_op_a * w_op_b;
        end
        if (r_state == ftm_pkg::SEQ_MUL_RPD) begin
            r_cmp <= r_prod[ftm_pkg::RECIP_SHIFT +: 16];
        end
    end

    // rpm < floor(p / 100) holds exactly when (rpm + 1) * 100 <= p.
    assign w_rpm_inc = {1'b0, i_state.rpm} + 17'd1;
    assign w_rpm_ext = {7'd0, w_rpm_inc};
    assign w_thresh  = (w_rpm_ext << 6) + (w_rpm_ext << 5) + (w_rpm_ext << 2);

    always_comb begin
        priority if (i_state.rpm == 16'd0 && i_state.duty != 7'd0) begin
            w_status = ftm_pkg::ST_STALL;
        end else if (w_thresh <= r_prod[23:0]) begin
            w_status = ftm_pkg::ST_UNDER;
        end else begin
            w_status = ftm_pkg::ST_OK;
        end
    end

    // Outputs.
    always_comb begin
        o_seq.busy          = (r_state != ftm_pkg::SEQ_IDLE);
        o_seq.load          = (r_state == ftm_pkg::SEQ_FINISH) && i_out_free;
        o_seq.compare_value = r_cmp;
        o_seq.fan_status    = w_status;
    end

endmodule

// File: hdl/fan_tach_monitor.sv
// Fan tachometer monitor: one result item per event, with speed, status and PWM compare.
// The result enters the output register at the finish step, once the output is free.
// An item runs four multiplier passes and a finish step; the next item enters only at idle.
// A result waiting at the output does not block the next item until its finish step.
// Reset (synchronous, active low) clears counters, speed, duty and loads register defaults.
// Depends on ftm_pkg, ftm_state, ftm_seq and assert_macros.svh.
`include "assert_macros.svh"

module fan_tach_monitor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  ftm_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output ftm_pkg::t_out_item o_item,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);

    logic [15:0] r_pwm_top;
    logic [9:0]  r_rpm_per_duty;
    logic [6:0]  r_tolerance_pct;
    logic [15:0] r_window_ms;

    logic               r_out_valid;
    ftm_pkg::t_out_item r_out_item;

    logic                w_accept;
    logic                w_out_free;
    ftm_pkg::t_evt_state w_state;
    ftm_pkg::t_seq_out   w_seq;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_top       <= ftm_pkg::RST_PWM_TOP;
            r_rpm_per_duty  <= ftm_pkg::RST_RPM_DUTY;
            r_tolerance_pct <= ftm_pkg::RST_TOL_PCT;
            r_window_ms     <= ftm_pkg::RST_WINDOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ftm_pkg::CFG_PWM_TOP:  r_pwm_top       <= i_cfg_data;
                ftm_pkg::CFG_RPM_DUTY: r_rpm_per_duty  <= i_cfg_data[9:0];
                ftm_pkg::CFG_TOL_PCT:  r_tolerance_pct <= i_cfg_data[6:0];
                ftm_pkg::CFG_WINDOW:   r_window_ms     <= i_cfg_data;
            endcase
        end
    end

    // Input handshake: an item enters only while the sequencer is idle and out of reset.
    assign o_stall    = w_seq.busy || !i_rst_n;
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    ftm_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_item),
        .i_window_ms (r_window_ms),
        .o_state     (w_state)
    );

    ftm_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_accept),
        .i_out_free      (w_out_free),
        .i_state         (w_state),
        .i_pwm_top       (r_pwm_top),
        .i_rpm_per_duty  (r_rpm_per_duty),
        .i_tolerance_pct (r_tolerance_pct),
        .o_seq           (w_seq)
    );

    // Output register holding one finished item until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_seq.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_seq.load) begin
            r_out_item.rpm_out       <= w_state.rpm;
            r_out_item.fan_status    <= w_seq.fan_status;
            r_out_item.compare_value <= w_seq.compare_value;
            r_out_item.window_done   <= w_state.done;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    // Checks on the block's own logic.
    `FTM_ASSERT(a_load_when_free, i_clk, i_rst_n, !w_seq.load || w_out_free,
        "result loaded over an untaken item")
    `FTM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, o_stall,
        "sequencer not busy after an accepted item")
    `FTM_ASSERT(a_cmp_within_top, i_clk, i_rst_n,
        !r_out_valid || (r_out_item.compare_value <= r_pwm_top),
        "compare value above PWM top")
    `FTM_ASSERT(a_stall_zero_rpm, i_clk, i_rst_n,
        !(r_out_valid && r_out_item.fan_status == ftm_pkg::ST_STALL)
            || (r_out_item.rpm_out == 16'd0),
        "stall reported with nonzero speed")

endmodule
